@@ hw/rtl/pssdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pssdt_pkg
// Shared types and constants of the parameter shadow store.
// ----------------------------------------------------------------------------
package pssdt_pkg;

  // number of parameter lists, 256 bytes each
  localparam int LIST_COUNT = 8;
  localparam int LIST_BYTES = 256;
  localparam int DEPTH      = LIST_COUNT * LIST_BYTES;
  localparam int AW         = $clog2(DEPTH);
  localparam int TW         = $clog2(DEPTH + 1);
  // width wide enough to compare a list number with LIST_COUNT
  localparam int LCW        = $clog2(LIST_COUNT + 1) + 1;

  // store word: {pending, used, data byte}
  localparam int WW = 10;

  // operation codes
  localparam logic [2:0] MODE_READ     = 3'd0;
  localparam logic [2:0] MODE_WRITE    = 3'd1;
  localparam logic [2:0] MODE_DEVICE   = 3'd2;
  localparam logic [2:0] MODE_FIND     = 3'd3;
  localparam logic [2:0] MODE_CLEAR    = 3'd4;
  localparam logic [2:0] MODE_MARK_ALL = 3'd5;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_EX,
    ST_FIN
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic start;
    logic rd;
    logic ex;
    logic fin;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic ex_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hw/rtl/pssdt_ctrl.sv @@
// ----------------------------------------------------------------------------
// pssdt_ctrl
// Sequencer: clearing pass after reset, then read / execute steps per item.
// ----------------------------------------------------------------------------
module pssdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pssdt_pkg::dp_sts_t sts_i,
  output pssdt_pkg::dp_cmd_t cmd_o
);

  pssdt_pkg::ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pssdt_pkg::ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pssdt_pkg::ST_CLR: begin
        if (sts_i.clr_last) state_d = pssdt_pkg::ST_IDLE;
      end
      pssdt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = pssdt_pkg::ST_RD;
      end
      pssdt_pkg::ST_RD: begin
        state_d = pssdt_pkg::ST_EX;
      end
      pssdt_pkg::ST_EX: begin
        state_d = sts_i.ex_last ? pssdt_pkg::ST_FIN : pssdt_pkg::ST_RD;
      end
      pssdt_pkg::ST_FIN: begin
        if (sts_i.out_free) state_d = pssdt_pkg::ST_IDLE;
      end
      default: state_d = pssdt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      pssdt_pkg::ST_CLR:  cmd_o.clr = 1'b1;
      pssdt_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      pssdt_pkg::ST_RD:   cmd_o.rd  = 1'b1;
      pssdt_pkg::ST_EX:   cmd_o.ex  = 1'b1;
      pssdt_pkg::ST_FIN:  cmd_o.fin = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/pssdt_dp.sv @@
// ----------------------------------------------------------------------------
// pssdt_dp
// Datapath: byte store with marks, pending count, item registers, result.
// ----------------------------------------------------------------------------
module pssdt_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pssdt_pkg::dp_cmd_t cmd_i,
  output pssdt_pkg::dp_sts_t sts_o,
  input  logic [2:0]         mode_i,
  input  logic [2:0]         list_sel_i,
  input  logic [7:0]         byte_pos_i,
  input  logic [2:0]         bit_pos_i,
  input  logic [2:0]         byte_count_i,
  input  logic [3:0]         bit_count_i,
  input  logic [31:0]        field_value_i,
  input  logic [31:0]        field_mask_i,
  input  logic               keep_pending_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        read_value_o,
  output logic               found_o,
  output logic [7:0]         found_index_o,
  output logic               any_pending_o
);

  localparam logic [pssdt_pkg::AW-1:0] SweepLast = pssdt_pkg::AW'(pssdt_pkg::DEPTH - 1);

  // item registers
  logic [2:0]  mode_q, list_q, bpos_q, bc_q;
  logic [3:0]  nbits_q;
  logic [31:0] val_q, msk_q;
  logic        keep_q;
  logic [7:0]  baddr_q;
  logic [2:0]  cnt_q;
  logic [pssdt_pkg::AW-1:0] sweep_q;
  logic [pssdt_pkg::TW-1:0] total_q;

  // accumulated result
  logic [31:0] rv_q;
  logic        fnd_q;
  logic [7:0]  fidx_q;

  // output register
  logic        ovld_q;
  logic [31:0] orv_q;
  logic        ofnd_q, oany_q;
  logic [7:0]  oidx_q;

  // store
  logic [pssdt_pkg::WW-1:0] mem_q [pssdt_pkg::DEPTH];
  logic [pssdt_pkg::WW-1:0] rdata_q, wdata;
  logic [pssdt_pkg::AW-1:0] addr;
  logic                     re, we;

  logic       list_ok, sweep_mode, sub, item_put, host;
  logic       ob_used, ob_pend, changed, new_pend;
  logic [7:0] ob, rbyte, ones8, m8, v8, nv;
  logic       ex_last;

  assign list_ok    = pssdt_pkg::LCW'(list_q) < pssdt_pkg::LCW'(pssdt_pkg::LIST_COUNT);
  assign sweep_mode = (mode_q == pssdt_pkg::MODE_CLEAR) || (mode_q == pssdt_pkg::MODE_MARK_ALL);
  assign sub        = (bc_q == 3'd0);
  assign ob         = rdata_q[7:0];
  assign ob_used    = rdata_q[8];
  assign ob_pend    = rdata_q[9];
  assign rbyte      = list_ok ? ob : 8'h00;
  assign ones8      = 8'((9'h001 << nbits_q) - 9'h001);

  // store address: sweep counter or list/byte address
  always_comb begin
    if (cmd_i.clr || sweep_mode) begin
      addr = sweep_q;
    end else begin
      addr = (pssdt_pkg::AW'(list_q) << 8) | pssdt_pkg::AW'(baddr_q);
    end
  end

  // new byte for a host or device store
  always_comb begin
    if (mode_q == pssdt_pkg::MODE_DEVICE) begin
      m8 = 8'hff;
      v8 = val_q[7:0];
    end else if (sub) begin
      m8 = msk_q[7:0] & (ones8 << bpos_q);
      v8 = val_q[7:0] << bpos_q;
    end else begin
      m8 = msk_q[7:0];
      v8 = val_q[7:0];
    end
    nv       = (rbyte & ~m8) | (v8 & m8);
    host     = (mode_q == pssdt_pkg::MODE_WRITE);
    changed  = (ob != nv) || !ob_used;
    new_pend = host ? (ob_pend || changed) : 1'b0;
    item_put = list_ok && (baddr_q != 8'h00) &&
               (host || ((mode_q == pssdt_pkg::MODE_DEVICE) && !(keep_q && ob_pend)));
  end

  // read / write enables and write word
  always_comb begin
    re    = cmd_i.rd && (sweep_mode || list_ok);
    we    = 1'b0;
    wdata = '0;
    if (cmd_i.clr) begin
      we = 1'b1;
    end else if (cmd_i.ex) begin
      case (mode_q) inside
        pssdt_pkg::MODE_WRITE, pssdt_pkg::MODE_DEVICE: begin
          we    = item_put;
          wdata = {new_pend, 1'b1, nv};
        end
        pssdt_pkg::MODE_CLEAR: begin
          we    = 1'b1;
          wdata = {1'b0, ob_used, ob};
        end
        pssdt_pkg::MODE_MARK_ALL: begin
          we    = 1'b1;
          wdata = {ob_used, ob_used, ob};
        end
        default: ;
      endcase
    end
  end

  // last step of the item
  always_comb begin
    case (mode_q) inside
      pssdt_pkg::MODE_FIND: ex_last = !list_ok || ob_pend || (baddr_q == 8'hff);
      pssdt_pkg::MODE_CLEAR, pssdt_pkg::MODE_MARK_ALL: ex_last = (sweep_q == SweepLast);
      default: ex_last = (cnt_q == 3'd1);
    endcase
  end

  assign sts_o.ex_last  = ex_last;
  assign sts_o.clr_last = (sweep_q == SweepLast);
  assign sts_o.out_free = !ovld_q || !out_stall_i;

  // store memory
  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr] <= wdata;
    if (re) rdata_q <= mem_q[addr];
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q  <= mode_i;
      list_q  <= list_sel_i;
      bpos_q  <= bit_pos_i;
      bc_q    <= (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
      nbits_q <= (bit_count_i > 4'd8) ? 4'd8 : bit_count_i;
      val_q   <= field_value_i;
      msk_q   <= field_mask_i;
      keep_q  <= keep_pending_i;
      if ((mode_i == pssdt_pkg::MODE_WRITE) && (byte_count_i != 3'd0)) begin
        baddr_q <= byte_pos_i + 8'(((byte_count_i > 3'd4) ? 3'd4 : byte_count_i) - 3'd1);
      end else begin
        baddr_q <= byte_pos_i;
      end
      rv_q   <= '0;
      fnd_q  <= 1'b0;
      fidx_q <= '0;
    end else if (cmd_i.ex) begin
      case (mode_q)
        pssdt_pkg::MODE_READ: begin
          if (sub) begin
            rv_q <= 32'((rbyte >> bpos_q) & msk_q[7:0] & ones8);
          end else begin
            rv_q <= {rv_q[23:0], rbyte};
          end
          baddr_q <= baddr_q + 8'd1;
        end
        pssdt_pkg::MODE_WRITE: begin
          baddr_q <= baddr_q - 8'd1;
          val_q   <= val_q >> 8;
          msk_q   <= msk_q >> 8;
        end
        pssdt_pkg::MODE_FIND: begin
          if (list_ok && ob_pend) begin
            fnd_q  <= 1'b1;
            fidx_q <= baddr_q;
            rv_q   <= 32'(ob);
          end
          baddr_q <= baddr_q + 8'd1;
        end
        default: ;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sweep_q <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        sweep_q <= sweep_q + pssdt_pkg::AW'(1);
        total_q <= '0;
      end else if (cmd_i.start) begin
        cnt_q   <= ((mode_i == pssdt_pkg::MODE_READ || mode_i == pssdt_pkg::MODE_WRITE) &&
                    byte_count_i != 3'd0) ?
                   ((byte_count_i > 3'd4) ? 3'd4 : byte_count_i) : 3'd1;
        sweep_q <= '0;
        if (mode_i == pssdt_pkg::MODE_CLEAR || mode_i == pssdt_pkg::MODE_MARK_ALL) begin
          total_q <= '0;
        end
      end else if (cmd_i.ex) begin
        cnt_q   <= cnt_q - 3'd1;
        sweep_q <= sweep_q + pssdt_pkg::AW'(1);
        case (mode_q)
          pssdt_pkg::MODE_WRITE: begin
            if (item_put && changed && !ob_pend) total_q <= total_q + pssdt_pkg::TW'(1);
          end
          pssdt_pkg::MODE_DEVICE: begin
            if (item_put && ob_pend) total_q <= total_q - pssdt_pkg::TW'(1);
          end
          pssdt_pkg::MODE_MARK_ALL: begin
            total_q <= total_q + pssdt_pkg::TW'(ob_used);
          end
          default: ;
        endcase
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (cmd_i.fin) begin
      ovld_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovld_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      orv_q  <= (mode_q == pssdt_pkg::MODE_READ) ? (rv_q & msk_q) : rv_q;
      ofnd_q <= fnd_q;
      oidx_q <= fidx_q;
      oany_q <= (total_q != '0);
    end
  end

  assign out_valid_o   = ovld_q;
  assign read_value_o  = orv_q;
  assign found_o       = ofnd_q;
  assign found_index_o = oidx_q;
  assign any_pending_o = oany_q;

`ifndef SYNTHESIS
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= pssdt_pkg::TW'(pssdt_pkg::DEPTH))
    else $error("pending count out of range");

  a_no_addr0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ex && we && (mode_q == pssdt_pkg::MODE_WRITE || mode_q == pssdt_pkg::MODE_DEVICE))
    |-> (baddr_q != 8'h00))
    else $error("store at byte address zero");

  a_cnt_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> (cnt_q != 3'd0))
    else $error("step count not loaded");
`endif

endmodule

@@ hw/rtl/param_shadow_store_dirty_track.sv @@
// ----------------------------------------------------------------------------
// param_shadow_store_dirty_track
// Shadow store of device parameter bytes with used and pending-write marks.
// ----------------------------------------------------------------------------
// After reset the block clears its store, one entry a cycle, over all
// LIST_COUNT*256 entries (2048 with eight lists) and takes no item meanwhile.
// It then works on one item at a time through a single-port store whose read
// data is registered: each byte touched gets a read step, then an update step.
// A field read or write touches one to four bytes between an accept step and
// a result step, a device store one byte, a pending search each byte scanned
// from the start address, and clearing or marking all pending every entry.
// The result waits in an output register, so the next item is taken while it
// is still stalled.
module param_shadow_store_dirty_track (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  list_sel_i,
  input  logic [7:0]  byte_pos_i,
  input  logic [2:0]  bit_pos_i,
  input  logic [2:0]  byte_count_i,
  input  logic [3:0]  bit_count_i,
  input  logic [31:0] field_value_i,
  input  logic [31:0] field_mask_i,
  input  logic        keep_pending_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_value_o,
  output logic        found_o,
  output logic [7:0]  found_index_o,
  output logic        any_pending_o
);

  pssdt_pkg::dp_cmd_t cmd;
  pssdt_pkg::dp_sts_t sts;

  // sequencer
  pssdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store and result datapath
  pssdt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_i),
    .list_sel_i     (list_sel_i),
    .byte_pos_i     (byte_pos_i),
    .bit_pos_i      (bit_pos_i),
    .byte_count_i   (byte_count_i),
    .bit_count_i    (bit_count_i),
    .field_value_i  (field_value_i),
    .field_mask_i   (field_mask_i),
    .keep_pending_i (keep_pending_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o),
    .found_o        (found_o),
    .found_index_o  (found_index_o),
    .any_pending_o  (any_pending_o)
  );

endmodule
